### hw/rtl/paged_framebuffer_line_raster_macros.svh
// Assertion macros shared by the framebuffer checker.
`ifndef PAGED_FRAMEBUFFER_LINE_RASTER_MACROS_SVH
`define PAGED_FRAMEBUFFER_LINE_RASTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PFB_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PFB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/pfb_pkg.sv
// Shared constants, types and address helpers for the paged framebuffer.
`timescale 1ns / 1ps
`default_nettype none

package pfb_pkg;

   // Panel geometry
   localparam int PANEL_WIDTH  = 128;
   localparam int PANEL_HEIGHT = 64;
   localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
   localparam int STORE_BYTES  = PAGE_COUNT * PANEL_WIDTH;
   localparam int ADDR_W       = $clog2(STORE_BYTES);

   // Coordinate and error widths
   localparam int COORD_W = 10;
   localparam int ERR_W   = 13;

   // Operation codes
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_SET   = 2'd1;
   localparam logic [1:0] OP_LINE  = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ERR_W-1:0]   err_type;
   typedef logic [ADDR_W-1:0]         addr_type;

   // Pixel read-modify-write request issued by the sequencer
   typedef struct packed {
      logic     vld;
      addr_type addr;
      logic [7:0] mask;
      logic     color;
   } pix_req_type;

   // Memory write port
   typedef struct packed {
      logic       en;
      addr_type   addr;
      logic [7:0] data;
   } mem_wr_type;

   // Pixel lies on the panel
   function automatic logic pixel_on_panel(input coord_type x, input coord_type y);
      logic x_ok;
      logic y_ok;
      x_ok = !x[COORD_W-1] && ({1'b0, x[COORD_W-2:0]} < COORD_W'(PANEL_WIDTH));
      y_ok = !y[COORD_W-1] && ({1'b0, y[COORD_W-2:0]} < COORD_W'(PANEL_HEIGHT));
      return x_ok && y_ok;
   endfunction

   // Byte index of an on-panel pixel: page * width + x
   function automatic addr_type pixel_addr(input coord_type x, input coord_type y);
      logic [15:0] idx;
      idx = 16'(y[COORD_W-2:3]) * 16'(PANEL_WIDTH) + 16'(x[COORD_W-2:0]);
      return idx[ADDR_W-1:0];
   endfunction

   // Bit of the pixel within its page byte
   function automatic logic [7:0] pixel_mask(input coord_type y);
      return 8'(1) << y[2:0];
   endfunction

   // Byte index for a read by page and column
   function automatic addr_type byte_addr(input logic [2:0] page, input logic [6:0] col);
      logic [15:0] idx;
      idx = 16'(page) * 16'(PANEL_WIDTH) + 16'(col);
      return idx[ADDR_W-1:0];
   endfunction

   // Read target lies inside the store
   function automatic logic byte_in_store(input logic [2:0] page, input logic [6:0] col);
      return (5'(page) < 5'(PAGE_COUNT)) && (9'(col) < 9'(PANEL_WIDTH));
   endfunction

endpackage

`default_nettype wire

### hw/rtl/paged_framebuffer_line_raster.sv
// States from the accepting edge to rsp_tvalid: set pixel and line pass ST_LINE,
// ST_DRAIN, ST_DONE; read ST_READ (in-store only), ST_DONE; clear ST_SWEEP, ST_DONE.
// Throughput: one command at a time; a line runs one pixel per cycle through the
// frame store read-modify-write pipeline; clear writes one byte per cycle.
// Reset is synchronous, active high; afterwards the store is zeroed by a
// sweep during which req_tready stays low.
`timescale 1ns / 1ps
`default_nettype none

module paged_framebuffer_line_raster
   import pfb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [9:0] start_x, [19:10] start_y, [29:20] end_x, [39:30] end_y, [40] color,
   // [43:41] read_page, [50:44] read_column, [55:51] zero
   input  wire logic [55:0] req_tdata,
   // [1:0] opcode
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] read_data
   output logic [7:0]       rsp_tdata,
   // [1:0] done_opcode
   output logic [1:0]       rsp_tuser
);

   typedef enum logic [5:0] {
      ST_SWEEP = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_LINE  = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_READ  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic       boot_ff, boot_in;
   addr_type   sweep_ff, sweep_in;
   logic [1:0] op_ff, op_in;
   logic       color_ff, color_in;
   logic [7:0] result_ff, result_in;
   logic       rsp_vld_ff, rsp_vld_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic [1:0] rsp_op_ff, rsp_op_in;

   // Request fields
   logic [1:0] f_opcode;
   coord_type  f_start_x;
   coord_type  f_start_y;
   coord_type  f_end_x;
   coord_type  f_end_y;
   logic       f_color;
   logic [2:0] f_page;
   logic [6:0] f_column;
   logic       req_xfer;

   assign f_opcode  = req_tuser;
   assign f_start_x = req_tdata[9:0];
   assign f_start_y = req_tdata[19:10];
   assign f_end_x   = req_tdata[29:20];
   assign f_end_y   = req_tdata[39:30];
   assign f_color   = req_tdata[40];
   assign f_page    = req_tdata[43:41];
   assign f_column  = req_tdata[50:44];
   assign req_xfer  = req_tvalid && req_tready;

   // Stepper and memory port signals
   logic        step_load;
   logic        step_adv;
   coord_type   step_x1;
   coord_type   step_y1;
   coord_type   pt_x;
   coord_type   pt_y;
   logic        pt_last;
   pix_req_type pix_req;
   mem_wr_type  rmw_wr;
   mem_wr_type  mem_wr;
   logic        rd_en;
   addr_type    rd_addr;
   logic [7:0]  rd_data;

   // A set pixel is a line whose end equals its start
   assign step_x1 = (f_opcode == OP_SET) ? f_start_x : f_end_x;
   assign step_y1 = (f_opcode == OP_SET) ? f_start_y : f_end_y;

   pfb_line_step u_step (
      .clock   (clock),
      .load    (step_load),
      .advance (step_adv),
      .x0      (f_start_x),
      .y0      (f_start_y),
      .x1      (step_x1),
      .y1      (step_y1),
      .pt_x    (pt_x),
      .pt_y    (pt_y),
      .last    (pt_last)
   );

   pfb_pixel_rmw u_rmw (
      .clock   (clock),
      .reset   (reset),
      .req     (pix_req),
      .rd_data (rd_data),
      .wr      (rmw_wr)
   );

   pfb_frame_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      boot_in     = boot_ff;
      sweep_in    = sweep_ff;
      op_in       = op_ff;
      color_in    = color_ff;
      result_in   = result_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_op_in   = rsp_op_ff;

      step_load     = 1'b0;
      step_adv      = 1'b0;
      pix_req.vld   = 1'b0;
      pix_req.addr  = pixel_addr(pt_x, pt_y);
      pix_req.mask  = pixel_mask(pt_y);
      pix_req.color = color_ff;
      rd_en         = 1'b0;
      rd_addr       = pixel_addr(pt_x, pt_y);
      mem_wr        = rmw_wr;

      unique case (state_ff)
         ST_SWEEP: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = sweep_ff;
            mem_wr.data = 8'h00;
            sweep_in    = sweep_ff + ADDR_W'(1);
            if (sweep_ff == ADDR_W'(STORE_BYTES - 1)) begin
               boot_in  = 1'b0;
               state_in = boot_ff ? ST_IDLE : ST_DONE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               op_in     = f_opcode;
               color_in  = f_color;
               result_in = 8'h00;
               unique case (f_opcode)
                  OP_CLEAR: begin
                     sweep_in = '0;
                     state_in = ST_SWEEP;
                  end
                  OP_SET, OP_LINE: begin
                     step_load = 1'b1;
                     state_in  = ST_LINE;
                  end
                  OP_READ: begin
                     rd_addr = byte_addr(f_page, f_column);
                     if (byte_in_store(f_page, f_column)) begin
                        rd_en    = 1'b1;
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_LINE: begin
            // One pixel issued per cycle; off-panel pixels are skipped
            pix_req.vld = pixel_on_panel(pt_x, pt_y);
            rd_en       = pix_req.vld;
            step_adv    = 1'b1;
            if (pt_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_READ: begin
            result_in = rd_data;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = result_ff;
               rsp_op_in   = op_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SWEEP;
         boot_ff    <= 1'b1;
         sweep_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         boot_ff    <= boot_in;
         sweep_ff   <= sweep_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      color_ff    <= color_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
      rsp_op_ff   <= rsp_op_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_op_ff;

endmodule

`default_nettype wire

### hw/rtl/pfb_frame_mem.sv
// Frame store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pfb_frame_mem
   import pfb_pkg::*;
(
   input  wire logic       clock,
   input  wire mem_wr_type wr,
   input  wire logic       rd_en,
   input  wire addr_type   rd_addr,
   output logic [7:0]      rd_data
);

   logic [7:0] mem [STORE_BYTES];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read port, registered, returns the old byte on a collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/pfb_line_step.sv
// Bresenham line stepper: holds the current point and advances one step per cycle while advance is high.
`timescale 1ns / 1ps
`default_nettype none

module pfb_line_step
   import pfb_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      load,
   input  wire logic      advance,
   input  wire coord_type x0,
   input  wire coord_type y0,
   input  wire coord_type x1,
   input  wire coord_type y1,
   output coord_type pt_x,
   output coord_type pt_y,
   output logic      last
);

   coord_type x_ff, x_in;
   coord_type y_ff, y_in;
   coord_type xe_ff, xe_in;
   coord_type ye_ff, ye_in;
   err_type   dx_ff, dx_in;
   err_type   dy_ff, dy_in;
   err_type   err_ff, err_in;
   logic      sx_ff, sx_in;
   logic      sy_ff, sy_in;

   logic signed [COORD_W:0]  diff_x;
   logic signed [COORD_W:0]  diff_y;
   logic signed [COORD_W:0]  abs_x;
   logic signed [COORD_W:0]  abs_y;
   logic signed [ERR_W:0]    e2;
   logic                     step_x;
   logic                     step_y;

   // Setup on load, error update on advance
   always_comb begin
      diff_x = {x1[COORD_W-1], x1} - {x0[COORD_W-1], x0};
      diff_y = {y1[COORD_W-1], y1} - {y0[COORD_W-1], y0};
      abs_x  = diff_x[COORD_W] ? -diff_x : diff_x;
      abs_y  = diff_y[COORD_W] ? -diff_y : diff_y;

      e2     = {err_ff, 1'b0};
      step_x = e2 >= $signed({dy_ff[ERR_W-1], dy_ff});
      step_y = e2 <= $signed({dx_ff[ERR_W-1], dx_ff});

      x_in   = x_ff;
      y_in   = y_ff;
      xe_in  = xe_ff;
      ye_in  = ye_ff;
      dx_in  = dx_ff;
      dy_in  = dy_ff;
      err_in = err_ff;
      sx_in  = sx_ff;
      sy_in  = sy_ff;

      if (load) begin
         x_in   = x0;
         y_in   = y0;
         xe_in  = x1;
         ye_in  = y1;
         dx_in  = ERR_W'(abs_x);
         dy_in  = -ERR_W'(abs_y);
         err_in = ERR_W'(abs_x) - ERR_W'(abs_y);
         sx_in  = x0 < x1;
         sy_in  = y0 < y1;
      end else if (advance) begin
         err_in = err_ff + (step_x ? dy_ff : '0) + (step_y ? dx_ff : '0);
         if (step_x) begin
            x_in = sx_ff ? x_ff + COORD_W'(1) : x_ff - COORD_W'(1);
         end
         if (step_y) begin
            y_in = sy_ff ? y_ff + COORD_W'(1) : y_ff - COORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      xe_ff  <= xe_in;
      ye_ff  <= ye_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      err_ff <= err_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
   end

   assign pt_x = x_ff;
   assign pt_y = y_ff;
   assign last = (x_ff == xe_ff) && (y_ff == ye_ff);

endmodule

`default_nettype wire

### hw/rtl/pfb_pixel_rmw.sv
// Pixel read-modify-write stage with forwarding of the previous write.
`timescale 1ns / 1ps
`default_nettype none

module pfb_pixel_rmw
   import pfb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire pix_req_type req,
   input  wire logic [7:0]  rd_data,
   output mem_wr_type wr
);

   logic       w_vld_ff, w_vld_in;
   addr_type   w_addr_ff;
   logic [7:0] w_mask_ff;
   logic       w_color_ff;

   logic       hold_vld_ff, hold_vld_in;
   addr_type   hold_addr_ff;
   logic [7:0] hold_data_ff;

   logic [7:0] base;
   logic [7:0] new_byte;

   // Write stage: read data arrives in the cycle after issue
   assign w_vld_in = req.vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_vld_ff <= 1'b0;
      end else begin
         w_vld_ff <= w_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      w_addr_ff  <= req.addr;
      w_mask_ff  <= req.mask;
      w_color_ff <= req.color;
   end

   // The write of the previous pixel lands after this byte was read
   always_comb begin
      base = (hold_vld_ff && (hold_addr_ff == w_addr_ff)) ? hold_data_ff : rd_data;
      new_byte = w_color_ff ? (base | w_mask_ff) : (base & ~w_mask_ff);
   end

   // Remember the write of this cycle for the next pixel
   assign hold_vld_in = w_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_addr_ff <= w_addr_ff;
      hold_data_ff <= new_byte;
   end

   assign wr.en   = w_vld_ff;
   assign wr.addr = w_addr_ff;
   assign wr.data = new_byte;

endmodule

`default_nettype wire

### hw/rtl/pfb_checker.sv
// Port-level checker for the framebuffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "paged_framebuffer_line_raster_macros.svh"

module pfb_checker
   import pfb_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [1:0] rsp_tuser
);

   // A stalled result holds its payload
   `PFB_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // Only a read returns data
   `PFB_ASSERT_SAME(a_rsp_zero, rsp_tvalid && (rsp_tuser != OP_READ), rsp_tdata == 8'h00, "non-read result carries data")

   // A command keeps the block busy for at least the next cycle
   `PFB_ASSERT_NEXT(a_req_busy, req_tvalid && req_tready, !req_tready, "command accepted back to back")

   // The store sweep after reset blocks commands and results
   `PFB_ASSERT_SAME(a_reset_sweep, $past(reset), !req_tready && !rsp_tvalid, "activity right after reset")

endmodule

bind paged_framebuffer_line_raster pfb_checker u_pfb_checker (.*);

`default_nettype wire
